// File: rtl/dkws_pkg.sv
// Package for the dual key window search block: widths, register indexes and the
// structs that pass between the window and the top level.
// No dependencies; the files that use it refer to it by scoped names.
package dkws_pkg;

	// Default key length in bytes.
	localparam int KEY_BYTES_DEF = 32;

	// Each key is held in four 64-bit configuration words.
	localparam int KEY_WORDS  = 4;
	localparam int KEY_WORD_W = 64;

	// The register index port is one bit wider than the register list needs,
	// so that writes beyond the list can arrive and be dropped.
	localparam int CFG_INDEX_W = 4;

	// Payload byte width.
	localparam int BYTE_W = 8;

	// Register index of the first word of each key.
	localparam logic [CFG_INDEX_W-1:0] KEY_A_WORD0 = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] KEY_B_WORD0 = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_END     = 4'd8;

	// One payload byte handed to the window, with its advance strobe.
	typedef struct packed {
		logic              advance;
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_packet;
	} step_t;

	// Match flags for the packet so far, including the byte being stepped.
	typedef struct packed {
		logic found_key_a;
		logic found_key_b;
	} match_t;

endpackage

// File: rtl/dkws_pkt_if.sv
// Byte stream channel: one payload byte and its last-byte flag per transaction.
// Uses dkws_pkg for the byte width.
interface dkws_pkt_if;
	logic                          valid;
	logic                          ready;
	logic [dkws_pkg::BYTE_W-1:0]   data_byte;
	logic                          end_of_packet;

	modport source (output valid, output data_byte, output end_of_packet, input ready);
	modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// File: rtl/dkws_res_if.sv
// Result channel: one transaction per packet with the two found flags.
// No dependencies.
interface dkws_res_if;
	logic valid;
	logic ready;
	logic found_key_a;
	logic found_key_b;

	modport source (output valid, output found_key_a, output found_key_b, input ready);
	modport sink   (input valid, input found_key_a, input found_key_b, output ready);
endinterface

// File: rtl/dkws_key_regs.sv
// Key configuration registers: eight 64-bit words, four per key.
// Depends on dkws_pkg for the register indexes and word sizes.
module dkws_key_regs #(
	parameter int KEY_BYTES = dkws_pkg::KEY_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [dkws_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dkws_pkg::KEY_WORD_W-1:0]      cfg_wdata,
	output logic [KEY_BYTES*dkws_pkg::BYTE_W-1:0] key_a,
	output logic [KEY_BYTES*dkws_pkg::BYTE_W-1:0] key_b
);

	localparam int WSEL_W = $clog2(dkws_pkg::KEY_WORDS);
	localparam int FLAT_W = dkws_pkg::KEY_WORDS * dkws_pkg::KEY_WORD_W;

	logic [dkws_pkg::KEY_WORDS-1:0][dkws_pkg::KEY_WORD_W-1:0] key_a_q;
	logic [dkws_pkg::KEY_WORDS-1:0][dkws_pkg::KEY_WORD_W-1:0] key_b_q;
	logic [FLAT_W-1:0] key_a_flat;
	logic [FLAT_W-1:0] key_b_flat;
	logic [WSEL_W-1:0] word_sel;
	logic              hit_a;
	logic              hit_b;

	// Decode the register index into a key and a word within it.
	assign hit_a    = cfg_wr_en && (cfg_index < dkws_pkg::KEY_B_WORD0);
	assign hit_b    = cfg_wr_en && (cfg_index >= dkws_pkg::KEY_B_WORD0)
	                  && (cfg_index < dkws_pkg::CFG_END);
	assign word_sel = cfg_index[WSEL_W-1:0];

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q <= '0;
			key_b_q <= '0;
		end else begin
			if (hit_a) begin
				key_a_q[word_sel] <= cfg_wdata;
			end
			if (hit_b) begin
				key_b_q[word_sel] <= cfg_wdata;
			end
		end
	end

	// Word 0 sits lowest, so key byte j lands in bits 8j+7..8j.
	assign key_a_flat = key_a_q;
	assign key_b_flat = key_b_q;
	assign key_a      = key_a_flat[KEY_BYTES*dkws_pkg::BYTE_W-1:0];
	assign key_b      = key_b_flat[KEY_BYTES*dkws_pkg::BYTE_W-1:0];

endmodule

// File: rtl/dkws_window.sv
// Sliding byte window with fill count and sticky match flags for both keys.
// Depends on dkws_pkg for the step and match structs.
module dkws_window #(
	parameter int KEY_BYTES = dkws_pkg::KEY_BYTES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dkws_pkg::step_t                       step,
	input  logic [KEY_BYTES*dkws_pkg::BYTE_W-1:0] key_a,
	input  logic [KEY_BYTES*dkws_pkg::BYTE_W-1:0] key_b,
	output dkws_pkg::match_t                      match
);

	localparam int WIN_DEPTH = KEY_BYTES - 1;
	localparam int CNT_W     = $clog2(KEY_BYTES);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIN_DEPTH);

	logic [WIN_DEPTH-1:0][dkws_pkg::BYTE_W-1:0] window_q;
	logic [KEY_BYTES-1:0][dkws_pkg::BYTE_W-1:0] win_full;
	logic [CNT_W-1:0] count_q;
	logic             seen_a_q;
	logic             seen_b_q;
	logic             full;
	logic             hit_a;
	logic             hit_b;

	// The stored bytes, oldest at index 0, plus the incoming byte on top.
	assign win_full = {step.data_byte, window_q};
	assign full     = (count_q == CNT_FULL);
	assign hit_a    = full && (win_full == key_a);
	assign hit_b    = full && (win_full == key_b);

	// Flags for the packet up to and including the incoming byte.
	assign match.found_key_a = seen_a_q || hit_a;
	assign match.found_key_b = seen_b_q || hit_b;

	// Byte shift line; its contents are ignored until the count fills again.
	always_ff @(posedge clk) begin
		if (step.advance) begin
			window_q <= {step.data_byte, window_q[WIN_DEPTH-1:1]};
		end
	end

	// Fill count and sticky flags; the last byte of a packet clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			seen_a_q <= 1'b0;
			seen_b_q <= 1'b0;
		end else if (step.advance) begin
			if (step.end_of_packet) begin
				count_q  <= '0;
				seen_a_q <= 1'b0;
				seen_b_q <= 1'b0;
			end else begin
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
				seen_a_q <= match.found_key_a;
				seen_b_q <= match.found_key_b;
			end
		end
	end

endmodule

// File: rtl/dual_key_window_search.sv
// Top level of the dual key window search: input register, window, result register.
// Depends on dkws_pkg, dkws_pkt_if, dkws_res_if, dkws_key_regs and dkws_window.
//
// The block takes one payload byte per clock cycle, save for the stall
// below, and searches every KEY_BYTES-byte window of the packet for two
// keys written through the configuration port (key A at indexes 0 to 3,
// key B at 4 to 7, earliest byte in the low bits of word 0). Each accepted
// byte is held in the input register and compared with both keys there,
// and the last byte's flags are then loaded into the result register,
// which offers the result of the packet. Bytes flow at one per cycle; the
// input stalls only when a last byte finds the result register still
// holding an earlier packet's result that the sink has not taken. Packets
// shorter than KEY_BYTES bytes report both keys as not found. Write the
// keys only while no packet is in flight.
module dual_key_window_search #(
	parameter int KEY_BYTES = dkws_pkg::KEY_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [dkws_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dkws_pkg::KEY_WORD_W-1:0]   cfg_wdata,
	dkws_pkt_if.sink                          pkt,
	dkws_res_if.source                        res
);

	logic [KEY_BYTES*dkws_pkg::BYTE_W-1:0] key_a;
	logic [KEY_BYTES*dkws_pkg::BYTE_W-1:0] key_b;
	logic                                  valid_s1;
	logic [dkws_pkg::BYTE_W-1:0]           data_s1;
	logic                                  eop_s1;
	logic                                  adv_s1;
	logic                                  pkt_fire;
	logic                                  res_valid_q;
	dkws_pkg::match_t                      res_q;
	dkws_pkg::step_t                       step;
	dkws_pkg::match_t                      match;

	// Key registers.
	dkws_key_regs #(
		.KEY_BYTES (KEY_BYTES)
	) u_key_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.key_a     (key_a),
		.key_b     (key_b)
	);

	// The byte in the input register moves on unless it is a last byte and
	// the result register cannot take its result this cycle.
	assign adv_s1   = valid_s1 && (!eop_s1 || !res_valid_q || res.ready);
	assign pkt.ready = !valid_s1 || adv_s1;
	assign pkt_fire = pkt.valid && pkt.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_fire) begin
			data_s1 <= pkt.data_byte;
			eop_s1  <= pkt.end_of_packet;
		end
	end

	// Window and compare.
	assign step.advance       = adv_s1;
	assign step.data_byte     = data_s1;
	assign step.end_of_packet = eop_s1;

	dkws_window #(
		.KEY_BYTES (KEY_BYTES)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.key_a  (key_a),
		.key_b  (key_b),
		.match  (match)
	);

	// Result register, loaded by the last byte of each packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && eop_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && eop_s1) begin
			res_q <= match;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.found_key_a = res_q.found_key_a;
	assign res.found_key_b = res_q.found_key_b;

	// A result appears only after a last byte left the input register.
	a_result_from_last_byte : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(adv_s1 && eop_s1))
		else $error("result raised without a last byte");

	// With the result register empty the input never stalls.
	a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> pkt.ready)
		else $error("input stalled while result register empty");

	// A byte held back in the input register is kept unchanged.
	a_s1_holds : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(data_s1) && $stable(eop_s1)))
		else $error("held input byte lost or changed");

endmodule
